@@ design/aba_pkg.sv @@
// ----------------------------------------------------------------------------
// aba_pkg: shared types and constants for the arena bump allocator
// Request and result payloads, request and status codes, and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package aba_pkg;

  // Field widths
  localparam int TYPE_W  = 3;
  localparam int ALLOC_W = 13;
  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 21;
  localparam int CAP_W   = 25;
  // Width of the rounded allocation size (alloc_bytes plus alignment slack)
  localparam int NEED_W  = 14;

  // Largest buffer that may be added
  localparam logic [BYTES_W-1:0] BUF_BYTES_MAX = 21'd1048576;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ALLOC  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_PUSH   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_POP    = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd5;

  // Status codes
  localparam logic [TYPE_W-1:0] ST_OK    = 3'd0;
  localparam logic [TYPE_W-1:0] ST_OOM   = 3'd1;
  localparam logic [TYPE_W-1:0] ST_FULL  = 3'd2;
  localparam logic [TYPE_W-1:0] ST_FRAME = 3'd3;
  localparam logic [TYPE_W-1:0] ST_NONE  = 3'd4;
  localparam logic [TYPE_W-1:0] ST_SIZE  = 3'd5;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [ALLOC_W-1:0] alloc_bytes;
    logic [ADDR_W-1:0]  buffer_base;
    logic [BYTES_W-1:0] buffer_bytes;
  } request_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  status;
    logic [ADDR_W-1:0]  alloc_address;
    logic [ADDR_W-1:0]  removed_base;
    logic [BYTES_W-1:0] removed_bytes;
    logic [CAP_W-1:0]   total_capacity;
  } result_t;

  // Datapath actions issued by the controller
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_FAIL,
    ACT_ADD,
    ACT_REM_RD,
    ACT_REM,
    ACT_ALLOC_RD,
    ACT_ALLOC_STEP,
    ACT_OOM,
    ACT_PUSH,
    ACT_POP_RD,
    ACT_POP,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    act_t              act;
    logic [TYPE_W-1:0] code;   // status recorded by ACT_FAIL
  } ctrl_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              add_bad_size;
    logic              add_full;
    logic              alloc_bad_size;
    logic              idx_lt_count;
    logic              removable;
    logic              frame_full;
    logic              frame_empty;
    logic              fit;
  } dp_flags_t;

endpackage

@@ design/aba_ram.sv @@
// ----------------------------------------------------------------------------
// aba_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/aba_ctrl.sv @@
// ----------------------------------------------------------------------------
// aba_ctrl: request sequencer for the arena bump allocator
// Decodes the latched request, walks the buffer table on allocation and
// signals completion of each request.
// ----------------------------------------------------------------------------
module aba_ctrl
  import aba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_flags_t flags,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  state_t state, state_next;
  logic   finish;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.act    = ACT_NONE;
    cmd.code   = ST_OK;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.act    = ACT_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        finish = 1'b1;
        unique case (flags.req_type)
          REQ_ADD: begin
            if (flags.add_bad_size) begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_SIZE;
            end else if (flags.add_full) begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_FULL;
            end else begin
              cmd.act = ACT_ADD;
            end
          end
          REQ_REMOVE: begin
            if (flags.removable) begin
              cmd.act = ACT_REM_RD;
              finish  = 1'b0;
            end else begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_NONE;
            end
          end
          REQ_ALLOC: begin
            if (flags.alloc_bad_size) begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_SIZE;
            end else if (flags.idx_lt_count) begin
              cmd.act = ACT_ALLOC_RD;
              finish  = 1'b0;
            end else begin
              cmd.act = ACT_OOM;
            end
          end
          REQ_PUSH: begin
            if (flags.frame_full) begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_FRAME;
            end else begin
              cmd.act = ACT_PUSH;
            end
          end
          REQ_POP: begin
            if (flags.frame_empty) begin
              cmd.act  = ACT_FAIL;
              cmd.code = ST_FRAME;
            end else begin
              cmd.act = ACT_POP_RD;
              finish  = 1'b0;
            end
          end
          REQ_CLEAR: begin
            cmd.act = ACT_CLEAR;
          end
          default: begin
            cmd.act = ACT_NONE;
          end
        endcase
        if (!finish) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        finish = 1'b1;
        unique case (flags.req_type)
          REQ_REMOVE: cmd.act = ACT_REM;
          REQ_POP:    cmd.act = ACT_POP;
          REQ_ALLOC: begin
            // place the allocation if it fits here, else try the next buffer
            cmd.act = ACT_ALLOC_STEP;
            if (!flags.fit) begin
              finish     = 1'b0;
              state_next = S_EXEC;
            end
          end
          default:    cmd.act = ACT_NONE;
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  // State and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/aba_datapath.sv @@
// ----------------------------------------------------------------------------
// aba_datapath: allocator state, buffer table and frame stack
// Holds the counters, top pointer and capacity, the buffer table RAM and the
// frame stack RAM, and carries out the actions the controller issues.
// ----------------------------------------------------------------------------
module aba_datapath
  import aba_pkg::*;
#(
  parameter int MAX_BUFFERS = 16,
  parameter int FRAME_DEPTH = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int ALIGN_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  request_t  request,
  input  ctrl_cmd_t cmd,
  output dp_flags_t flags,
  output result_t   result
);

  // Counter and address widths
  localparam int CW  = $clog2(MAX_BUFFERS + 1);
  localparam int BAW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int FCW = $clog2(FRAME_DEPTH + 1);
  localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int TW  = ADDR_W + BYTES_W;
  localparam int FW  = CW + BYTES_W;

  // Round-up by reciprocal multiplication: exact for sums below 2^NEED_W
  localparam int ALIGN_L = $clog2(ALIGN_BYTES);
  localparam int K       = NEED_W + ALIGN_L;
  localparam int MW      = K + 1;
  localparam logic [MW-1:0] RECIP = MW'(((1 << K) + ALIGN_BYTES - 1) / ALIGN_BYTES);
  localparam logic [NEED_W-1:0] ALIGN_M1 = NEED_W'(ALIGN_BYTES - 1);
  localparam logic [6:0] ALIGN_V = 7'(ALIGN_BYTES);

  localparam logic [CW-1:0]      MAX_V   = CW'(MAX_BUFFERS);
  localparam logic [FCW-1:0]     FRAME_V = FCW'(FRAME_DEPTH);
  localparam logic [BYTES_W-1:0] PAGE_V  = BYTES_W'(PAGE_BYTES);

  request_t           req;
  logic [NEED_W-1:0]  q;
  logic [NEED_W-1:0]  need;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [BYTES_W-1:0] top;
  logic [CAP_W-1:0]   cap;
  logic [FCW-1:0]     depth;
  logic [TYPE_W-1:0]  st;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  rbase;
  logic [BYTES_W-1:0] rbytes;

  logic [NEED_W-1:0]    x_sum;
  logic [NEED_W+MW-1:0] x_prod;
  logic [NEED_W+6:0]    need_prod;
  logic [CAP_W:0]       cap_sum;
  logic [CW-1:0]        count_dec;
  logic [FCW-1:0]       depth_dec;
  logic [BAW-1:0]       tab_raddr;
  logic [TW-1:0]        tab_rdata;
  logic [FW-1:0]        frm_rdata;
  logic [ADDR_W-1:0]    tab_base;
  logic [BYTES_W-1:0]   tab_size;
  logic [BYTES_W-1:0]   room;

  // Rounded size: quotient on the incoming request, multiple in the cycle after it is latched
  assign x_sum     = {1'b0, request.alloc_bytes} + ALIGN_M1;
  assign x_prod    = x_sum * RECIP;
  assign need_prod = q * ALIGN_V;

  assign cap_sum   = {1'b0, cap} + {{(CAP_W - BYTES_W + 1){1'b0}}, req.buffer_bytes};
  assign count_dec = count - CW'(1);
  assign depth_dec = depth - FCW'(1);

  // Buffer table: base and size side by side
  assign tab_raddr = (cmd.act == ACT_REM_RD) ? count_dec[BAW-1:0] : idx[BAW-1:0];
  assign tab_base  = tab_rdata[TW-1:BYTES_W];
  assign tab_size  = tab_rdata[BYTES_W-1:0];

  aba_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_BUFFERS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.act == ACT_ADD),
    .waddr (count[BAW-1:0]),
    .wdata ({req.buffer_base, req.buffer_bytes}),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Frame stack: saved index and top
  aba_ram #(
    .WIDTH (FW),
    .DEPTH (FRAME_DEPTH)
  ) u_frames (
    .clk   (clk),
    .we    (cmd.act == ACT_PUSH),
    .waddr (depth[FAW-1:0]),
    .wdata ({idx, top}),
    .raddr (depth_dec[FAW-1:0]),
    .rdata (frm_rdata)
  );

  // Status flags for the controller
  assign room = tab_size - top;
  always_comb begin
    flags.req_type       = req.req_type;
    flags.add_bad_size   = (req.buffer_bytes < PAGE_V) || (req.buffer_bytes > BUF_BYTES_MAX);
    flags.add_full       = (count >= MAX_V) || cap_sum[CAP_W];
    flags.alloc_bad_size = ({{(BYTES_W - ALLOC_W){1'b0}}, req.alloc_bytes} > PAGE_V);
    flags.idx_lt_count   = (idx < count);
    flags.removable      = (idx < count) && (count != '0);
    flags.frame_full     = (depth >= FRAME_V);
    flags.frame_empty    = (depth == '0);
    flags.fit            = (top <= tab_size) &&
                           ({{(BYTES_W - NEED_W){1'b0}}, need} <= room);
  end

  // Rounded size pipeline, free running
  always_ff @(posedge clk) begin
    need <= need_prod[NEED_W-1:0];
  end

  // Allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      top   <= '0;
      cap   <= '0;
      depth <= '0;
    end else begin
      unique case (cmd.act)
        ACT_ADD: begin
          count <= count + CW'(1);
          cap   <= cap_sum[CAP_W-1:0];
        end
        ACT_REM: begin
          count <= count_dec;
          cap   <= cap - {{(CAP_W - BYTES_W){1'b0}}, tab_size};
        end
        ACT_ALLOC_STEP: begin
          if (flags.fit) begin
            top <= top + {{(BYTES_W - NEED_W){1'b0}}, need};
          end else begin
            idx <= idx + CW'(1);
            top <= '0;
          end
        end
        ACT_OOM: begin
          if (idx > count) begin
            idx <= count;
          end
          top <= '0;
        end
        ACT_PUSH: begin
          depth <= depth + FCW'(1);
        end
        ACT_POP: begin
          depth <= depth_dec;
          idx   <= frm_rdata[FW-1:BYTES_W];
          top   <= frm_rdata[BYTES_W-1:0];
        end
        ACT_CLEAR: begin
          idx <= '0;
          top <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Request latch and result fields
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_LOAD: begin
        req    <= request;
        q      <= x_prod[K +: NEED_W];
        st     <= ST_OK;
        addr   <= '0;
        rbase  <= '0;
        rbytes <= '0;
      end
      ACT_FAIL: st <= cmd.code;
      ACT_OOM:  st <= ST_OOM;
      ACT_REM: begin
        rbase  <= tab_base;
        rbytes <= tab_size;
      end
      ACT_ALLOC_STEP: begin
        if (flags.fit) begin
          addr <= tab_base + {{(ADDR_W - BYTES_W){1'b0}}, top};
        end
      end
      default: begin
      end
    endcase
  end

  assign result.status         = st;
  assign result.alloc_address  = addr;
  assign result.removed_base   = rbase;
  assign result.removed_bytes  = rbytes;
  assign result.total_capacity = cap;

endmodule

@@ design/arena_bump_allocator_with_frames_unit.sv @@
// ----------------------------------------------------------------------------
// arena_bump_allocator_with_frames_unit: bump allocator with frame stack
// Bump allocation over a table of buffers, with add/remove of buffers,
// mark/release frames and clear.
//
//   channel   ports                     direction  handshake
//   request   start, busy, request      in         start && !busy
//   result    done, result              out        done, one cycle
//
// Add, push, clear and rejected requests pass through a load and an execute
// step; remove and pop add a wait step for the registered table or frame read.
// An allocation takes an execute and a wait step for every buffer it examines,
// set by the registered buffer table read, and an out-of-memory one ends in execute.
// The result is valid in the cycle after the last step, while busy is low.
// Synchronous reset empties the table and frame stack (counts to zero).
// The receiver cannot stall; no result is held back.
// ----------------------------------------------------------------------------
module arena_bump_allocator_with_frames_unit
  import aba_pkg::*;
#(
  parameter int MAX_BUFFERS = 16,
  parameter int FRAME_DEPTH = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int ALIGN_BYTES = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  ctrl_cmd_t cmd;
  dp_flags_t flags;

  // Request sequencer
  aba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Allocator state and storage
  aba_datapath #(
    .MAX_BUFFERS (MAX_BUFFERS),
    .FRAME_DEPTH (FRAME_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .flags   (flags),
    .result  (result)
  );

  // A result only appears once the sequencer has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Every result follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // A failed request reports no address and no removed buffer
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.alloc_address == '0 && result.removed_base == '0 &&
       result.removed_bytes == '0))
    else $error("failed request carries payload");

endmodule

@@ verif/tb_arena_bump_allocator_with_frames_unit.sv @@
// ----------------------------------------------------------------------------
// tb_arena_bump_allocator_with_frames_unit: self-checking bench for the arena
// bump allocator
// Requests go in through start/busy. A scoreboard keeps its own copy of the
// buffer table, bump pointer and frame stack, and works out the expected
// result of every accepted request. Each done strobe is then compared field
// by field with the oldest expected result. A short directed run covers the
// corner cases. Random sequences of allocate, frame, add and remove traffic
// follow, with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_arena_bump_allocator_with_frames_unit;
  import aba_pkg::*;

  // Block configuration (matches the defaults of the unit)
  localparam int unsigned MAX_BUFS    = 16;
  localparam int unsigned FRAME_SLOTS = 16;
  localparam int unsigned PAGE        = 4096;
  localparam int unsigned ALIGN       = 8;
  localparam logic [25:0] CAP_LIMIT   = 26'h1FF_FFFF;

  // Request codes the unit ignores
  localparam logic [TYPE_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_RSVD_B = 3'd7;

  // Shadow of the allocator state, with the results still to come out
  class alloc_tracker;
    logic [ADDR_W-1:0]  base_tab [MAX_BUFS];
    logic [BYTES_W-1:0] size_tab [MAX_BUFS];
    logic [4:0]         buf_total = '0;
    logic [4:0]         cur_buf   = '0;
    logic [BYTES_W-1:0] bump_top  = '0;
    logic [CAP_W-1:0]   cap_sum   = '0;
    logic [4:0]         mark_buf [FRAME_SLOTS];
    logic [BYTES_W-1:0] mark_top [FRAME_SLOTS];
    logic [4:0]         marks     = '0;
    result_t            pending_results[$];
    int                 mismatches = 0;

    // Apply one accepted request and queue the result it must produce
    function void note_request(request_t r);
      result_t     want;
      int unsigned need;
      logic        placed;
      want   = '0;
      placed = 1'b0;
      want.status = ST_OK;
      case (r.req_type)
        REQ_ADD: begin
          if (r.buffer_bytes < PAGE || r.buffer_bytes > BUF_BYTES_MAX) begin
            want.status = ST_SIZE;
          end else if (buf_total >= MAX_BUFS ||
                       ({1'b0, cap_sum} + 26'(r.buffer_bytes)) > CAP_LIMIT) begin
            want.status = ST_FULL;
          end else begin
            base_tab[buf_total] = r.buffer_base;
            size_tab[buf_total] = r.buffer_bytes;
            buf_total = buf_total + 5'd1;
            cap_sum   = cap_sum + CAP_W'(r.buffer_bytes);
          end
        end
        REQ_REMOVE: begin
          if (cur_buf < buf_total) begin
            buf_total = buf_total - 5'd1;
            want.removed_base  = base_tab[buf_total];
            want.removed_bytes = size_tab[buf_total];
            cap_sum = cap_sum - CAP_W'(size_tab[buf_total]);
          end else begin
            want.status = ST_NONE;
          end
        end
        REQ_ALLOC: begin
          if (r.alloc_bytes > PAGE) begin
            want.status = ST_SIZE;
          end else begin
            need = ((int'(r.alloc_bytes) + ALIGN - 1) / ALIGN) * ALIGN;
            // walk forward until a buffer has room; a stale top counts as full
            while (!placed && cur_buf < buf_total) begin
              if (bump_top <= size_tab[cur_buf] &&
                  need <= int'(size_tab[cur_buf] - bump_top)) begin
                want.alloc_address = base_tab[cur_buf] + ADDR_W'(bump_top);
                bump_top = bump_top + BYTES_W'(need);
                placed = 1'b1;
              end else begin
                cur_buf  = cur_buf + 5'd1;
                bump_top = '0;
              end
            end
            if (!placed) begin
              if (cur_buf > buf_total) cur_buf = buf_total;
              bump_top = '0;
              want.status = ST_OOM;
            end
          end
        end
        REQ_PUSH: begin
          if (marks >= FRAME_SLOTS) begin
            want.status = ST_FRAME;
          end else begin
            mark_buf[marks] = cur_buf;
            mark_top[marks] = bump_top;
            marks = marks + 5'd1;
          end
        end
        REQ_POP: begin
          if (marks == 0) begin
            want.status = ST_FRAME;
          end else begin
            marks    = marks - 5'd1;
            cur_buf  = mark_buf[marks];
            bump_top = mark_top[marks];
          end
        end
        REQ_CLEAR: begin
          cur_buf  = '0;
          bump_top = '0;
        end
        default: ;
      endcase
      want.total_capacity = cap_sum;
      pending_results.insert(pending_results.size(), want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one strobed result with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("alloc_address", want.alloc_address, got.alloc_address);
      compare_field("removed_base", want.removed_base, got.removed_base);
      compare_field("removed_bytes", 32'(want.removed_bytes), 32'(got.removed_bytes));
      compare_field("total_capacity", 32'(want.total_capacity),
                    32'(got.total_capacity));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  alloc_tracker tracker = new;
  bit           steady_pacing = 1'b0;
  int           sent = 0;

  arena_bump_allocator_with_frames_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  // Results are strobed for one cycle; take them at the closing edge
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  function automatic request_t make_req(logic [TYPE_W-1:0] kind, logic [ALLOC_W-1:0] nbytes,
                                        logic [ADDR_W-1:0] base, logic [BYTES_W-1:0] bsize);
    request_t r;
    r.req_type     = kind;
    r.alloc_bytes  = nbytes;
    r.buffer_base  = base;
    r.buffer_bytes = bsize;
    return r;
  endfunction

  // Mostly short gaps, some long, none while pacing is steady
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady_pacing || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [ALLOC_W-1:0] rand_alloc_bytes();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return ALLOC_W'($urandom_range(PAGE + 1, 8191));
    if (p < 10) return '0;
    if (p < 20) return ALLOC_W'($urandom_range(PAGE - 7, PAGE));
    if (p < 70) return ALLOC_W'($urandom_range(1, 256));
    return ALLOC_W'($urandom_range(1, PAGE));
  endfunction

  function automatic logic [BYTES_W-1:0] rand_buffer_bytes();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return BYTES_W'($urandom_range(0, PAGE - 1));
    if (p < 8) return BYTES_W'($urandom_range(1048577, 2097151));
    if (p < 15) return BUF_BYTES_MAX;
    if (p < 70) return BYTES_W'($urandom_range(PAGE, 4 * PAGE));
    return BYTES_W'($urandom_range(PAGE, 1048576));
  endfunction

  // Present one request, hold it until taken, then idle for a random gap, which may be empty
  task automatic send_request(request_t r);
    int gap;
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(r);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_kind(logic [TYPE_W-1:0] kind);
    send_request(make_req(kind, rand_alloc_bytes(), $urandom, rand_buffer_bytes()));
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed corner cases
    send_request(make_req(REQ_ALLOC,  13'd16, '0, '0));            // nothing to allocate from
    send_request(make_req(REQ_REMOVE, '0, '0, '0));                // empty table
    send_request(make_req(REQ_POP,    '0, '0, '0));                // empty frame stack
    send_request(make_req(REQ_ADD,    '0, 32'h1000, 21'd4095));    // below a page
    send_request(make_req(REQ_ADD,    13'h1FFF, 32'hFFFF_FFFF, 21'h1F_FFFF));
    send_request(make_req(REQ_ADD,    '0, 32'h2000, 21'd1048577)); // just above the max
    send_request(make_req(REQ_ADD,    '0, 32'hFFFF_FFF0, 21'd4096));
    send_request(make_req(REQ_ADD,    '0, 32'h8000_0000, BUF_BYTES_MAX));
    send_request(make_req(REQ_ALLOC,  13'd0, '0, '0));             // zero bytes
    send_request(make_req(REQ_ALLOC,  13'h1FFF, '0, '0));          // bad size
    send_request(make_req(REQ_ALLOC,  13'd4097, '0, '0));
    send_request(make_req(REQ_ALLOC,  13'd17, '0, '0));            // rounds up to 24
    send_request(make_req(REQ_PUSH,   '0, '0, '0));
    send_request(make_req(REQ_ALLOC,  13'd1, '0, '0));             // address wraps
    send_request(make_req(REQ_ALLOC,  13'd4096, '0, '0));          // skips to next buffer
    send_request(make_req(REQ_ALLOC,  13'd8, '0, '0));
    send_request(make_req(REQ_PUSH,   '0, '0, '0));
    send_request(make_req(REQ_CLEAR,  '0, '0, '0));
    send_request(make_req(REQ_REMOVE, '0, '0, '0));
    send_request(make_req(REQ_POP,    '0, '0, '0));                // mark past the table
    send_request(make_req(REQ_ADD,    '0, 32'h1234_5000, 21'd4096));
    send_request(make_req(REQ_ALLOC,  13'd8, '0, '0));             // stale top, then out of memory
    send_request(make_req(REQ_REMOVE, '0, '0, '0));                // nothing removable
    send_request(make_req(REQ_RSVD_A, 13'h0AAA, 32'h5555_5555, 21'h0A_AAAA));
    send_request(make_req(REQ_RSVD_B, 13'h1555, 32'hAAAA_AAAA, 21'h15_5555));
    drain_results();

    // Random sequences
    while (sent < 900) begin
      steady_pacing = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) send_kind(REQ_ALLOC);
      end else if (pick < 55) begin
        // mark, allocate, release
        send_kind(REQ_PUSH);
        n = $urandom_range(0, 5);
        repeat (n) send_kind(REQ_ALLOC);
        send_kind(REQ_POP);
      end else if (pick < 65) begin
        n = $urandom_range(1, 4);
        repeat (n) send_kind(REQ_ADD);
      end else if (pick < 73) begin
        if ($urandom_range(0, 1)) send_kind(REQ_CLEAR);
        n = $urandom_range(1, 3);
        repeat (n) send_kind(REQ_REMOVE);
      end else if (pick < 78) begin
        n = $urandom_range(1, 18);
        repeat (n) send_kind(REQ_PUSH);
      end else if (pick < 83) begin
        n = $urandom_range(1, 18);
        repeat (n) send_kind(REQ_POP);
      end else if (pick < 88) begin
        send_kind(REQ_CLEAR);
      end else if (pick < 93) begin
        // noise: any code, any field value
        n = $urandom_range(1, 4);
        repeat (n) send_request(make_req(TYPE_W'($urandom_range(0, 7)),
                                         ALLOC_W'($urandom_range(0, 8191)), $urandom,
                                         BYTES_W'($urandom_range(0, 2097151))));
      end else if (pick < 97) begin
        // fill the table, usually with big buffers
        n = $urandom_range(4, 17);
        repeat (n) send_request(make_req(REQ_ADD, rand_alloc_bytes(), $urandom,
                                         $urandom_range(0, 1) ? BUF_BYTES_MAX :
                                         BYTES_W'($urandom_range(PAGE, 1048576))));
      end else begin
        // settle, then empty the table
        drain_results();
        send_kind(REQ_CLEAR);
        repeat (17) send_kind(REQ_REMOVE);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
